// ===== rtl/klc_pkg.sv =====
// Shared types, codes and reset defaults for the keypad lock controller.
// Used by every module of the block but klc_ram; depends on nothing else.
`default_nettype none

package klc_pkg;

    localparam int USERS_DEF       = 5;
    localparam int CODE_DIGITS_DEF = 3;
    localparam int TABLE_BITS      = 60;
    localparam logic [TABLE_BITS-1:0] ID_TABLE_RESET = 60'd86152238561648913;

    // Request codes on the cmd field.
    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_ADMIN = 2'd1;
    localparam logic [1:0] CMD_USER  = 2'd2;

    // Key codes: 0-9 are digits.
    localparam logic [3:0] KEY_STAR = 4'd10;
    localparam logic [3:0] KEY_MAX  = 4'd11;

    typedef enum logic [2:0] {
        EV_TAKEN      = 3'd0,
        EV_WRONG_ID   = 3'd1,
        EV_WRONG_CODE = 3'd2,
        EV_DOOR_OPEN  = 3'd3,
        EV_CONTACT    = 3'd4,
        EV_STORED     = 3'd5,
        EV_IGNORED    = 3'd6
    } event_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_ID       = 4'd1,
        PH_CODE     = 4'd2,
        PH_ADM_CODE = 4'd3,
        PH_TARGET   = 4'd4,
        PH_ADM_NEW  = 4'd5,
        PH_CHG_ID   = 4'd6,
        PH_OLD      = 4'd7,
        PH_USR_NEW  = 4'd8,
        PH_REENTER  = 4'd9
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] key;
    } key_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] beeps;
        logic       unlock;
        logic [3:0] prompt;
    } result_t;

    // Factory passcode of a user; users beyond the fifth start at zero.
    function automatic logic [31:0] default_code(input int idx);
        logic [31:0] code;
        case (idx)
            0:       code = 32'h203;
            1:       code = 32'h129;
            2:       code = 32'h325;
            3:       code = 32'h426;
            4:       code = 32'h079;
            default: code = 32'h0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/klc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
`default_nettype none

module klc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 5,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/klc_code_store.sv =====
// Passcode store: RAM plus per-entry valid bits that stand for the factory
// defaults, and a bypass for a read of the entry being written. Uses klc_pkg, klc_ram.
`default_nettype none

module klc_code_store #(
    parameter int USERS     = klc_pkg::USERS_DEF,
    parameter int CODE_BITS = 4 * klc_pkg::CODE_DIGITS_DEF,
    localparam int UW = (USERS > 1) ? $clog2(USERS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [UW-1:0]        raddr,
    output logic      [CODE_BITS-1:0] rcode,
    input  wire logic                 we,
    input  wire logic [UW-1:0]        waddr,
    input  wire logic [CODE_BITS-1:0] wdata
);
    import klc_pkg::*;

    logic [USERS-1:0]     valid_reg;
    logic                 rd_valid_reg;
    logic                 fwd_reg;
    logic [CODE_BITS-1:0] fwd_data_reg;
    logic [UW-1:0]        raddr_reg;
    logic [CODE_BITS-1:0] ram_rdata;
    logic [31:0]          dflt_wide;

    klc_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (USERS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            raddr_reg    <= '0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
            fwd_reg      <= we && (waddr == raddr);
            raddr_reg    <= raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
    end

    assign dflt_wide = default_code(int'(raddr_reg));

    // A write to the entry under read wins over the RAM's old data.
    always_comb
    begin
        if (fwd_reg)
        begin
            rcode = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rcode = ram_rdata;
        end
        else
        begin
            rcode = dflt_wide[CODE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keypad_lock_controller.sv =====
// Keypad lock controller: each result is registered in the output register,
// or in the skid stage while res stalls; one key item is taken every cycle as
// long as res drains. The passcodes live in a RAM with a registered read,
// prefetched at the address the next item will need. Reset (rst_n,
// asynchronous) puts the lock idle, loads the default ID table and makes every
// user's code read as its factory default until it is first changed.
`default_nettype none

module keypad_lock_controller #(
    parameter int USERS       = klc_pkg::USERS_DEF,
    parameter int CODE_DIGITS = klc_pkg::CODE_DIGITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration: the user ID table.
    input  wire logic                            cfg_we,
    input  wire logic [klc_pkg::TABLE_BITS-1:0]  cfg_wdata,
    // Key and request items.
    input  wire logic                            key_valid,
    output logic                                 key_stall,
    input  wire klc_pkg::key_item_t              key_item,
    // Results.
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output klc_pkg::result_t                     res
);
    import klc_pkg::*;

    localparam int CODE_BITS = 4 * CODE_DIGITS;
    localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int DW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

    // Session state.
    phase_t               phase_reg, phase_next;
    logic [DW-1:0]        cnt_reg, cnt_next;
    logic [CODE_BITS-1:0] entry_reg, entry_next;
    logic [CODE_BITS-1:0] first_reg, first_next;
    logic [UW-1:0]        sel_reg, sel_next;
    logic [TABLE_BITS-1:0] id_table_reg;

    // Output register and skid stage.
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic                 accept;
    logic                 out_fire;
    result_t              result_new;
    logic [CODE_BITS+3:0] shift_wide;
    logic [CODE_BITS-1:0] entry_shift;
    logic                 last_digit;
    logic [63:0]          table64;
    logic [USERS-1:0]     match_vec;
    logic                 id_hit;
    logic [UW-1:0]        id_idx;
    logic [CODE_BITS-1:0] stored_code;
    logic                 code_ok;
    logic [UW-1:0]        st_raddr;
    logic                 st_we;

    assign accept   = key_valid && !key_stall;
    assign out_fire = out_valid_reg && !res_stall;

    // The skid stage being full is the only reason to hold the key side.
    assign key_stall = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // The newest key joins the collected digits at the low end.
    assign shift_wide  = {entry_reg, key_item.key};
    assign entry_shift = shift_wide[CODE_BITS-1:0];
    assign last_digit  = (cnt_reg == DW'(CODE_DIGITS - 1));

    // ID lookup: one compare per table entry, lowest matching index wins.
    // Entries that would reach past bit 63 never match.
    assign table64 = {{(64 - TABLE_BITS){1'b0}}, id_table_reg};

    for (genvar i = 0; i < USERS; i++)
    begin : g_match
        if ((i + 1) * CODE_BITS <= 64)
        begin : g_fit
            assign match_vec[i] = (table64[i*CODE_BITS +: CODE_BITS] == entry_shift);
        end
        else
        begin : g_out
            assign match_vec[i] = 1'b0;
        end
    end

    always_comb
    begin
        id_hit = 1'b0;
        id_idx = '0;
        for (int i = USERS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                id_hit = 1'b1;
                id_idx = UW'(i);
            end
        end
    end

    // The passcode the pending phase compares against was prefetched in the
    // previous cycle, so it is ready as soon as the key arrives.
    klc_code_store #(
        .USERS     (USERS),
        .CODE_BITS (CODE_BITS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (st_raddr),
        .rcode (stored_code),
        .we    (st_we),
        .waddr (sel_reg),
        .wdata (entry_shift)
    );

    assign code_ok = (stored_code == entry_shift);

    // The admin check always reads user 0; every other check reads the
    // selected user.
    assign st_raddr = (phase_next == PH_ADM_CODE) ? '0 : sel_next;

    always_comb
    begin
        phase_next           = phase_reg;
        cnt_next             = cnt_reg;
        entry_next           = entry_reg;
        first_next           = first_reg;
        sel_next             = sel_reg;
        st_we                = 1'b0;
        result_new.event_res = EV_TAKEN;
        result_new.beeps     = 2'd0;
        result_new.unlock    = 1'b0;

        if (accept)
        begin
            case (key_item.cmd)
                CMD_ADMIN:
                begin
                    phase_next = PH_ADM_CODE;
                    cnt_next   = '0;
                    entry_next = '0;
                end
                CMD_USER:
                begin
                    phase_next = PH_CHG_ID;
                    cnt_next   = '0;
                    entry_next = '0;
                end
                CMD_KEY:
                begin
                    if (key_item.key > KEY_MAX)
                    begin
                        result_new.event_res = EV_IGNORED;
                    end
                    else
                    begin
                        case (phase_reg) inside
                            PH_IDLE:
                            begin
                                if (key_item.key == KEY_STAR)
                                begin
                                    phase_next = PH_ID;
                                    cnt_next   = '0;
                                    entry_next = '0;
                                end
                                else
                                begin
                                    result_new.event_res = EV_IGNORED;
                                end
                            end
                            [PH_ID:PH_REENTER]:
                            begin
                                // Every key code up to KEY_MAX counts as a digit here.
                                entry_next = entry_shift;
                                cnt_next   = cnt_reg + DW'(1);
                                if (last_digit)
                                begin
                                    phase_next = PH_IDLE;
                                    cnt_next   = '0;
                                    entry_next = '0;
                                    case (phase_reg)
                                        PH_ID:
                                        begin
                                            if (id_hit)
                                            begin
                                                sel_next   = id_idx;
                                                phase_next = PH_CODE;
                                            end
                                            else
                                            begin
                                                result_new.event_res = EV_WRONG_ID;
                                                result_new.beeps     = 2'd2;
                                            end
                                        end
                                        PH_CODE:
                                        begin
                                            if (code_ok)
                                            begin
                                                result_new.event_res = EV_DOOR_OPEN;
                                                result_new.unlock    = 1'b1;
                                            end
                                            else
                                            begin
                                                result_new.event_res = EV_WRONG_CODE;
                                                result_new.beeps     = 2'd1;
                                            end
                                        end
                                        PH_ADM_CODE, PH_OLD:
                                        begin
                                            if (code_ok)
                                            begin
                                                phase_next = (phase_reg == PH_ADM_CODE) ?
                                                             PH_TARGET : PH_USR_NEW;
                                            end
                                            else
                                            begin
                                                result_new.event_res = EV_CONTACT;
                                                result_new.beeps     = 2'd2;
                                            end
                                        end
                                        PH_TARGET, PH_CHG_ID:
                                        begin
                                            if (id_hit)
                                            begin
                                                sel_next   = id_idx;
                                                phase_next = (phase_reg == PH_TARGET) ?
                                                             PH_ADM_NEW : PH_OLD;
                                            end
                                            else
                                            begin
                                                result_new.event_res = EV_CONTACT;
                                                result_new.beeps     = 2'd2;
                                            end
                                        end
                                        PH_ADM_NEW:
                                        begin
                                            st_we                = 1'b1;
                                            result_new.event_res = EV_STORED;
                                        end
                                        PH_USR_NEW:
                                        begin
                                            first_next = entry_shift;
                                            phase_next = PH_REENTER;
                                        end
                                        PH_REENTER:
                                        begin
                                            if (entry_shift == first_reg)
                                            begin
                                                st_we                = 1'b1;
                                                result_new.event_res = EV_STORED;
                                            end
                                            else
                                            begin
                                                result_new.event_res = EV_CONTACT;
                                                result_new.beeps     = 2'd2;
                                            end
                                        end
                                        default:
                                        begin
                                            phase_next = PH_IDLE;
                                        end
                                    endcase
                                end
                            end
                            default:
                            begin
                                // An unknown phase falls back to idle.
                                phase_next           = PH_IDLE;
                                cnt_next             = '0;
                                entry_next           = '0;
                                result_new.event_res = EV_IGNORED;
                            end
                        endcase
                    end
                end
                default:
                begin
                    result_new.event_res = EV_IGNORED;
                end
            endcase
        end

        result_new.prompt = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            entry_reg    <= '0;
            first_reg    <= '0;
            sel_reg      <= '0;
            id_table_reg <= ID_TABLE_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            entry_reg <= entry_next;
            first_reg <= first_next;
            sel_reg   <= sel_next;
            if (cfg_we)
            begin
                id_table_reg <= cfg_wdata;
            end
        end
    end

    // Result transfer: the output register is refilled from the skid stage
    // first, so results leave in the order their keys arrived.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= result_new;
            end
            else
            begin
                out_reg <= result_new;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/keypad_lock_controller_tb.sv =====
// Self-checking testbench for keypad_lock_controller: keypad logins, admin and user passcode
// changes, ignored items and ID table settings, with bursty input and a stalling receiver.
// Depends on the klc_pkg package and on the block's RTL in rtl/ with its submodules.
`default_nettype none

module keypad_lock_controller_tb;

    import klc_pkg::*;

    // Request code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Key codes beyond the star that matter here.
    localparam logic [3:0] KEY_HASH   = KEY_MAX;
    localparam logic [3:0] KEY_BAD    = 4'd15;
    localparam logic [3:0] KEY_LOWBAD = 4'd12;

    localparam int NUM_USERS   = USERS_DEF;
    localparam int CODE_LEN    = CODE_DIGITS_DEF;
    localparam int CODE_W      = 4 * CODE_LEN;

    localparam logic [1:0] BEEPS_NONE  = 2'd0;
    localparam logic [1:0] BEEPS_SHORT = 2'd1;
    localparam logic [1:0] BEEPS_LONG  = 2'd2;

    // Receiver stall patterns.
    localparam logic [1:0] STALL_NONE     = 2'd0;
    localparam logic [1:0] STALL_LIGHT    = 2'd1;
    localparam logic [1:0] STALL_HEAVY    = 2'd2;
    localparam logic [1:0] STALL_PERIODIC = 2'd3;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 5;
    localparam int ITEMS_PER_PHASE = 226;
    localparam int MAX_PRINTED    = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [TABLE_BITS-1:0] cfg_wdata;
    logic                  key_valid;
    logic                  key_stall;
    key_item_t             key_item;
    logic                  res_valid;
    logic                  res_stall;
    result_t               res;

    keypad_lock_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key_item  (key_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Predicted lock state. It is advanced once per accepted key transfer,
    // in the same order the block sees the transfers.
    logic [TABLE_BITS-1:0] id_table;
    phase_t                lock_phase;
    int                    digits_taken;
    logic [CODE_W-1:0]     digit_buf;
    logic [CODE_W-1:0]     pending_code;
    int                    chosen_user;
    logic [CODE_W-1:0]     user_code [NUM_USERS];

    // Outcomes predicted for accepted transfers whose result is not back yet.
    result_t outcome_queue [$];

    int mismatch_count;
    int cycle_count;
    int items_sent;
    int burst_left;
    bit need_abort;

    logic [1:0] stall_mode;
    int         stall_run;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Lock predictor
    // ------------------------------------------------------------------

    function automatic void enter_phase(phase_t p);
        lock_phase   = p;
        digits_taken = 0;
        digit_buf    = '0;
    endfunction

    // Lowest table index whose ID equals the typed digits, or -1 if none.
    function automatic int lookup_user(logic [CODE_W-1:0] id);
        for (int i = 0; i < NUM_USERS; i++)
        begin
            if (id_table[i*CODE_W +: CODE_W] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic void reset_lock_model();
        id_table     = ID_TABLE_RESET;
        enter_phase(PH_IDLE);
        pending_code = '0;
        chosen_user  = 0;
        user_code[0] = 12'h203;
        user_code[1] = 12'h129;
        user_code[2] = 12'h325;
        user_code[3] = 12'h426;
        user_code[4] = 12'h079;
    endfunction

    // Advances the lock state by one transfer and returns the result it causes.
    function automatic result_t lock_outcome(key_item_t it);
        result_t           r;
        logic [CODE_W-1:0] typed;
        phase_t            was;
        int                hit;
        r.event_res = EV_TAKEN;
        r.beeps     = BEEPS_NONE;
        r.unlock    = 1'b0;
        // A request always wins, even in the middle of a session.
        if (it.cmd == CMD_ADMIN)
            enter_phase(PH_ADM_CODE);
        else if (it.cmd == CMD_USER)
            enter_phase(PH_CHG_ID);
        else if (it.cmd == CMD_UNUSED || it.key > KEY_MAX)
            r.event_res = EV_IGNORED;
        else if (lock_phase == PH_IDLE)
        begin
            if (it.key == KEY_STAR)
                enter_phase(PH_ID);
            else
                r.event_res = EV_IGNORED;
        end
        else
        begin
            // In a session, star and hash are collected like digits.
            digit_buf = {digit_buf[CODE_W-5:0], it.key};
            digits_taken++;
            if (digits_taken >= CODE_LEN)
            begin
                typed = digit_buf;
                was   = lock_phase;
                enter_phase(PH_IDLE);
                case (was)
                    PH_ID:
                    begin
                        hit = lookup_user(typed);
                        if (hit < 0)
                        begin
                            r.event_res = EV_WRONG_ID;
                            r.beeps     = BEEPS_LONG;
                        end
                        else
                        begin
                            chosen_user = hit;
                            enter_phase(PH_CODE);
                        end
                    end
                    PH_CODE:
                    begin
                        if (user_code[chosen_user] == typed)
                        begin
                            r.event_res = EV_DOOR_OPEN;
                            r.unlock    = 1'b1;
                        end
                        else
                        begin
                            r.event_res = EV_WRONG_CODE;
                            r.beeps     = BEEPS_SHORT;
                        end
                    end
                    PH_ADM_CODE:
                    begin
                        if (user_code[0] == typed)
                            enter_phase(PH_TARGET);
                        else
                        begin
                            r.event_res = EV_CONTACT;
                            r.beeps     = BEEPS_LONG;
                        end
                    end
                    PH_TARGET, PH_CHG_ID:
                    begin
                        hit = lookup_user(typed);
                        if (hit < 0)
                        begin
                            r.event_res = EV_CONTACT;
                            r.beeps     = BEEPS_LONG;
                        end
                        else
                        begin
                            chosen_user = hit;
                            if (was == PH_TARGET)
                                enter_phase(PH_ADM_NEW);
                            else
                                enter_phase(PH_OLD);
                        end
                    end
                    PH_ADM_NEW:
                    begin
                        user_code[chosen_user] = typed;
                        r.event_res = EV_STORED;
                    end
                    PH_OLD:
                    begin
                        if (user_code[chosen_user] == typed)
                            enter_phase(PH_USR_NEW);
                        else
                        begin
                            r.event_res = EV_CONTACT;
                            r.beeps     = BEEPS_LONG;
                        end
                    end
                    PH_USR_NEW:
                    begin
                        pending_code = typed;
                        enter_phase(PH_REENTER);
                    end
                    default:
                    begin
                        // Re-entry must repeat the new code exactly.
                        if (typed == pending_code)
                        begin
                            user_code[chosen_user] = typed;
                            r.event_res = EV_STORED;
                        end
                        else
                        begin
                            r.event_res = EV_CONTACT;
                            r.beeps     = BEEPS_LONG;
                        end
                    end
                endcase
            end
        end
        r.prompt = lock_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %0d, want %0d",
                     cycle_count, what, got, want);
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (outcome_queue.size() == 0)
            report_mismatch("result transfer with nothing outstanding, event", got.event_res, -1);
        else
        begin
            want = outcome_queue.pop_front();
            if (got.event_res !== want.event_res)
                report_mismatch("event_res", got.event_res, want.event_res);
            if (got.beeps !== want.beeps)
                report_mismatch("beeps", got.beeps, want.beeps);
            if (got.unlock !== want.unlock)
                report_mismatch("unlock", got.unlock, want.unlock);
            if (got.prompt !== want.prompt)
                report_mismatch("prompt", got.prompt, want.prompt);
        end
    endtask

    // Both handshakes are sampled at the clock edge, before any of this edge's
    // nonblocking updates land. A result is retired before the new transfer's
    // outcome is queued, since the result always belongs to an earlier transfer.
    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            check_result(res);
        if (key_valid && !key_stall)
            outcome_queue.push_back(lock_outcome(key_item));
    end

    // Receiver: switches between stall patterns after runs of random length,
    // including long stretches with no stall at all.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_run  <= $urandom_range(20, 200);
        end
        else
            stall_run <= stall_run - 1;
        case (stall_mode)
            STALL_NONE:  res_stall <= 1'b0;
            STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
            default:     res_stall <= (stall_run % 3 == 0);
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d outcomes outstanding",
                     cycle_count, outcome_queue.size());
            $display("** keypad_lock_controller: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one key transfer. The sender works in bursts; between bursts it usually
    // drops valid for a random gap. Within a burst valid stays high and only
    // the payload moves on after each accepted transfer.
    task automatic send_item(key_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                key_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        key_item  <= it;
        key_valid <= 1'b1;
        do
            @(posedge clk);
        while (key_stall);
        items_sent++;
    endtask

    task automatic send_key(logic [1:0] cmd, logic [3:0] key);
        key_item_t it;
        it.cmd = cmd;
        it.key = key;
        send_item(it);
    endtask

    // Types a code or an ID, first digit in the top nibble.
    task automatic type_value(logic [CODE_W-1:0] v);
        for (int i = CODE_LEN - 1; i >= 0; i--)
            send_key(CMD_KEY, v[i*4 +: 4]);
    endtask

    // Mostly plain digits, with star and hash now and then.
    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] v;
        for (int i = 0; i < CODE_LEN; i++)
            v[i*4 +: 4] = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 9))
                                                       : 4'($urandom_range(10, 11));
        return v;
    endfunction

    function automatic bit keypad_can_type(logic [CODE_W-1:0] v);
        for (int i = 0; i < CODE_LEN; i++)
        begin
            if (v[i*4 +: 4] > KEY_MAX)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Usually an ID from the table; otherwise random digits, which may or
    // may not happen to match an entry.
    function automatic logic [CODE_W-1:0] pick_id();
        logic [CODE_W-1:0] v;
        v = id_table[$urandom_range(0, NUM_USERS - 1) * CODE_W +: CODE_W];
        if ($urandom_range(0, 99) >= 85 || !keypad_can_type(v))
            v = random_code();
        return v;
    endfunction

    function automatic logic [CODE_W-1:0] maybe_right(logic [CODE_W-1:0] right);
        return ($urandom_range(0, 99) < 80) ? right : random_code();
    endfunction

    // Lets every outstanding result drain with valid low, then writes the table.
    // The first edge makes sure the last accepted transfer has been queued.
    task automatic write_id_table(logic [TABLE_BITS-1:0] v);
        key_valid <= 1'b0;
        @(posedge clk);
        while (outcome_queue.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        id_table   = v;
        burst_left = 0;
    endtask

    // Random table whose IDs can all be typed, with duplicates now and then.
    function automatic logic [TABLE_BITS-1:0] random_id_table();
        logic [TABLE_BITS-1:0] v;
        int                    src;
        for (int i = 0; i < NUM_USERS; i++)
        begin
            v[i*CODE_W +: CODE_W] = random_code();
            if (i > 0 && $urandom_range(0, 3) == 0)
            begin
                src = $urandom_range(0, i - 1);
                v[i*CODE_W +: CODE_W] = v[src*CODE_W +: CODE_W];
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Well-formed flows. Each one stops as soon as the lock has gone back
    // to idle, so the next flow starts from a known phase.
    // ------------------------------------------------------------------

    task automatic run_login();
        logic [CODE_W-1:0] id;
        int                hit;
        send_key(CMD_KEY, KEY_STAR);
        id = pick_id();
        type_value(id);
        hit = lookup_user(id);
        if (hit >= 0)
            type_value(maybe_right(user_code[hit]));
    endtask

    task automatic run_admin_change();
        logic [CODE_W-1:0] v;
        int                hit;
        send_key(CMD_ADMIN, 4'($urandom_range(0, 15)));
        v = maybe_right(user_code[0]);
        type_value(v);
        if (v != user_code[0])
            return;
        v = pick_id();
        type_value(v);
        hit = lookup_user(v);
        if (hit >= 0)
            type_value(random_code());
    endtask

    task automatic run_user_change();
        logic [CODE_W-1:0] v;
        logic [CODE_W-1:0] fresh;
        int                hit;
        send_key(CMD_USER, 4'($urandom_range(0, 15)));
        v = pick_id();
        type_value(v);
        hit = lookup_user(v);
        if (hit < 0)
            return;
        v = maybe_right(user_code[hit]);
        type_value(v);
        if (v != user_code[hit])
            return;
        fresh = random_code();
        type_value(fresh);
        type_value(maybe_right(fresh));
    endtask

    // Random items of any kind; the lock may be left mid-session.
    task automatic run_noise();
        repeat ($urandom_range(1, 4))
            send_key(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        need_abort = 1'b1;
    endtask

    // A flow cut short after a few digits.
    task automatic run_broken_flow();
        case ($urandom_range(0, 2))
            0:       send_key(CMD_KEY, KEY_STAR);
            1:       send_key(CMD_ADMIN, 4'($urandom_range(0, 15)));
            default: send_key(CMD_USER, 4'($urandom_range(0, 15)));
        endcase
        repeat ($urandom_range(1, 5))
            send_key(CMD_KEY, 4'($urandom_range(0, 11)));
        need_abort = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle hash, out-of-range key codes and the unused request code.
    task automatic test_ignored_items();
        send_key(CMD_KEY, KEY_HASH);
        send_key(CMD_KEY, KEY_BAD);
        send_key(CMD_UNUSED, 4'd0);
        send_key(CMD_KEY, KEY_LOWBAD);
    endtask

    // A session is opened, then a user request aborts it, then an admin
    // request aborts that in turn and goes on to store a code made of a
    // star, a hash and a zero for the last user.
    task automatic test_request_abort_and_admin();
        send_key(CMD_KEY, KEY_STAR);
        send_key(CMD_KEY, 4'd7);
        send_key(CMD_USER, 4'd0);
        send_key(CMD_ADMIN, KEY_BAD);
        type_value(user_code[0]);
        type_value(id_table[(NUM_USERS-1)*CODE_W +: CODE_W]);
        type_value({KEY_STAR, KEY_HASH, 4'd0});
    endtask

    // Logs the last user in with the code just stored.
    task automatic test_login_star_hash_code();
        send_key(CMD_KEY, KEY_STAR);
        type_value(id_table[(NUM_USERS-1)*CODE_W +: CODE_W]);
        type_value(user_code[NUM_USERS-1]);
    endtask

    // An all-zero table makes every entry the same, so the lowest index must
    // win; an all-ones table can never match a typed ID; a table with a
    // duplicated entry checks the lowest index again with the table written
    // from scratch.
    task automatic test_id_table_extremes();
        logic [TABLE_BITS-1:0] dup;
        write_id_table('0);
        send_key(CMD_KEY, KEY_STAR);
        type_value('0);
        type_value(user_code[0]);
        write_id_table('1);
        send_key(CMD_KEY, KEY_STAR);
        type_value('0);
        send_key(CMD_USER, 4'd0);
        type_value({KEY_HASH, KEY_HASH, KEY_HASH});
        dup = random_id_table();
        dup[3*CODE_W +: CODE_W] = 12'h555;
        dup[1*CODE_W +: CODE_W] = 12'h555;
        write_id_table(dup);
        send_key(CMD_KEY, KEY_STAR);
        type_value(12'h555);
        type_value(user_code[lookup_user(12'h555)]);
    endtask

    // Several table settings, each followed by a mix of mostly complete
    // flows with random content, some noise and some broken flows.
    task automatic test_random_traffic();
        logic [63:0] wide;
        int          goal;
        int          pick;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: write_id_table(ID_TABLE_RESET);
                3:
                begin
                    wide = {$urandom, $urandom};
                    write_id_table(wide[TABLE_BITS-1:0]);
                end
                default: write_id_table(random_id_table());
            endcase
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                // After noise or a broken flow only a request gets the lock
                // back to a known phase.
                if (need_abort)
                begin
                    pick = (pick < 50) ? 40 : 60;
                    need_abort = 1'b0;
                end
                if (pick < 35)
                    run_login();
                else if (pick < 55)
                    run_admin_change();
                else if (pick < 75)
                    run_user_change();
                else if (pick < 88)
                    run_noise();
                else
                    run_broken_flow();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        key_valid      = 1'b0;
        key_item       = '0;
        res_stall      = 1'b0;
        stall_mode     = STALL_NONE;
        stall_run      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_sent     = 0;
        burst_left     = 0;
        need_abort     = 1'b0;
        reset_lock_model();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_items();
        test_request_abort_and_admin();
        test_login_star_hash_code();
        test_id_table_extremes();
        test_random_traffic();

        // Drain: every outstanding result must arrive; the watchdog covers a hang.
        // The first edge makes sure the last accepted transfer has been queued.
        key_valid <= 1'b0;
        @(posedge clk);
        while (outcome_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("** keypad_lock_controller: PASSED **");
        else
            $display("** keypad_lock_controller: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/klc_pkg.sv
rtl/klc_ram.sv
rtl/klc_code_store.sv
rtl/keypad_lock_controller.sv
tb/keypad_lock_controller_tb.sv
